@@ rtl/pal_pkg.sv @@
// Shared types and codes for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int POS_W         = 5;
    localparam int STATUS_W      = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [POS_W-1:0]        found_position;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]        count;
    } res_t;

endpackage

@@ rtl/pal_mem.sv @@
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pal_mem #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [pal_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [pal_pkg::DATA_W-1:0] rdata
);

    logic [pal_pkg::DATA_W-1:0] mem [DEPTH];
    logic [pal_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pal_ctrl.sv @@
// Command sequencer: checks, memory walks for shift/find/read, result hold.
`timescale 1ns / 1ps

module pal_ctrl #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pal_pkg::CMD_W-1:0]   in_cmd,
    input  logic [pal_pkg::DATA_W-1:0]  in_val,
    input  logic [pal_pkg::POS_W-1:0]   in_pos,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pal_pkg::res_t               res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [pal_pkg::DATA_W-1:0]  mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [pal_pkg::DATA_W-1:0]  mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [pal_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [pal_pkg::DATA_W-1:0]      val_reg, val_next;
    logic [AW-1:0]                   p0_reg, p0_next;
    logic [AW-1:0]                   rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                   last_reg, last_next;
    logic                            more_reg, more_next;
    logic                            pend_reg, pend_next;
    logic [AW-1:0]                   pend_addr_reg, pend_addr_next;
    logic [pal_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [EW-1:0]                   found_reg, found_next;
    logic [pal_pkg::DATA_W-1:0]      rdv_reg, rdv_next;

    logic [EW-1:0] pos_e;
    logic [EW-1:0] cnt_e;
    logic [EW-1:0] cnt_ext_out;

    assign pos_e       = EW'(in_pos);
    assign cnt_e       = EW'(count_reg);
    assign cnt_ext_out = EW'(count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign mem_raddr = rd_idx_reg;

    always_comb
    begin
        res.status         = status_reg;
        res.found_position = found_reg[pal_pkg::POS_W-1:0];
        res.read_value     = rdv_reg;
        res.count          = cnt_ext_out[pal_pkg::POS_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        p0_next        = p0_reg;
        rd_idx_next    = rd_idx_reg;
        last_next      = last_reg;
        more_next      = more_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rdv_next       = rdv_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = in_cmd;
                    val_next    = in_val;
                    p0_next     = AW'(pos_e - EW'(1));
                    status_next = pal_pkg::ST_OK;
                    found_next  = '0;
                    rdv_next    = '0;
                    more_next   = 1'b1;
                    state_next  = S_DONE;
                    unique case (in_cmd)
                        pal_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pal_pkg::CMD_APPEND:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = pal_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = in_val;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pal_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = pal_pkg::ST_FULL;
                            end
                            else if (pos_e == '0 || pos_e > cnt_e + EW'(1))
                            begin
                                status_next = pal_pkg::ST_BADPOS;
                            end
                            else if (pos_e == cnt_e + EW'(1))
                            begin
                                // insert at the tail: nothing to move
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = in_val;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                rd_idx_next = AW'(count_reg - CW'(1));
                                last_next   = AW'(pos_e - EW'(1));
                                state_next  = S_WALK;
                            end
                        end
                        pal_pkg::CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = pal_pkg::ST_EMPTY;
                            end
                            else if (pos_e == '0 || pos_e > cnt_e)
                            begin
                                status_next = pal_pkg::ST_BADPOS;
                            end
                            else if (pos_e == cnt_e)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                rd_idx_next = AW'(pos_e);
                                last_next   = AW'(count_reg - CW'(1));
                                state_next  = S_WALK;
                            end
                        end
                        pal_pkg::CMD_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = pal_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                last_next   = AW'(count_reg - CW'(1));
                                state_next  = S_WALK;
                            end
                        end
                        pal_pkg::CMD_READ:
                        begin
                            if (pos_e == '0 || pos_e > cnt_e)
                            begin
                                status_next = pal_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                rd_idx_next = AW'(pos_e - EW'(1));
                                last_next   = AW'(pos_e - EW'(1));
                                state_next  = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = pal_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // issue one read per cycle; handle the word read last cycle
                if (more_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = rd_idx_reg;
                    if (rd_idx_reg == last_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else if (cmd_reg == pal_pkg::CMD_INSERT)
                    begin
                        rd_idx_next = rd_idx_reg - AW'(1);
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    case (cmd_reg)
                        pal_pkg::CMD_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + AW'(1);
                            mem_wdata = mem_rdata;
                            if (!more_reg)
                            begin
                                state_next = S_PUT;
                            end
                        end
                        pal_pkg::CMD_DELETE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - AW'(1);
                            mem_wdata = mem_rdata;
                            if (!more_reg)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = S_DONE;
                            end
                        end
                        pal_pkg::CMD_FIND:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                found_next  = EW'(pend_addr_reg) + EW'(1);
                                status_next = pal_pkg::ST_OK;
                                pend_next   = 1'b0;
                                state_next  = S_DONE;
                            end
                            else if (!more_reg)
                            begin
                                status_next = pal_pkg::ST_NOTFOUND;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            rdv_next   = mem_rdata;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p0_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        p0_reg        <= p0_next;
        rd_idx_reg    <= rd_idx_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        rdv_reg       <= rdv_next;
    end

endmodule

@@ rtl/positional_array_list_top.sv @@
// Top level of the positional array list: stream ports, sequencer, storage, output register.
// Flow: clear, append and rejected commands go straight to the result; read fetches its
//   entry and insert/delete/find walk up to all entries, one entry a cycle through the
//   single memory read port. One command in work at a time. The next command is taken
//   while a result waits in the output register.
// Reset: rst_n async active low empties the list; entry storage is not cleared.
`timescale 1ns / 1ps

module positional_array_list_top #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[2:0], value[34:3], position[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], found_position[7:3], read_value[39:8],
                                   // count[44:40], zero[47:45]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        res_valid;
    logic                        res_ready;
    pal_pkg::res_t               res;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [pal_pkg::DATA_W-1:0]  mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [pal_pkg::DATA_W-1:0]  mem_rdata;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    pal_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[2:0]),
        .in_val    (s_tdata[34:3]),
        .in_pos    (s_tdata[39:35]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    pal_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= {3'b000, res.count, res.read_value,
                             res.found_position, res.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the positional array list: random commands, stream stalls.
`timescale 1ns / 1ps

module tb;
    import pal_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEFAULT;
    localparam int PHASE_ITEMS  = 460;
    localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // command[2:0], value[34:3], position[39:35]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // status[2:0], found_position[7:3], read_value[39:8],
                                  // count[44:40], zero[47:45]

    int idle_pct  = 0;
    int stall_pct = 0;

    // fill burst: grow the list to full, then poke it while full
    bit fill_active = 1'b0;
    int full_pokes  = 0;

    class list_tracker;
        logic [DATA_W-1:0] words [LIST_DEPTH];
        int                len;
        res_t              pending_results [$];
        int                mismatches;

        function new();
            foreach (words[i]) words[i] = '0;
            len        = 0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Update the list copy for one accepted transaction and queue its result.
        function void apply_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val,
                                    logic [POS_W-1:0] pos);
            res_t r;
            int   p;
            int   i;
            r = '0;
            p = int'(pos);
            case (cmd)
                CMD_CLEAR: len = 0;
                CMD_APPEND:
                    if (len >= LIST_DEPTH) r.status = ST_FULL;
                    else begin
                        words[len] = val;
                        len++;
                    end
                CMD_INSERT:
                    if (len >= LIST_DEPTH) r.status = ST_FULL;
                    else if (p == 0 || p - 1 > len) r.status = ST_BADPOS;
                    else begin
                        for (i = len; i > p - 1; i--) words[i] = words[i-1];
                        words[p-1] = val;
                        len++;
                    end
                CMD_DELETE:
                    if (len == 0) r.status = ST_EMPTY;
                    else if (p == 0 || p > len) r.status = ST_BADPOS;
                    else begin
                        for (i = p - 1; i + 1 < len; i++) words[i] = words[i+1];
                        len--;
                    end
                CMD_FIND: begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < len; i++) begin
                        if (words[i] == val) begin
                            r.status         = ST_OK;
                            r.found_position = POS_W'(i + 1);
                            break;
                        end
                    end
                end
                CMD_READ:
                    if (p == 0 || p > len) r.status = ST_BADPOS;
                    else r.read_value = words[p-1];
                default: ;
            endcase
            r.count = POS_W'(len);
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [47:0] d);
            res_t exp_r;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected, data %h", d));
                return;
            end
            exp_r = pending_results.pop_front();
            if (d[2:0] !== exp_r.status)
                report($sformatf("status %0d, expected %0d", d[2:0], exp_r.status));
            if (d[7:3] !== exp_r.found_position)
                report($sformatf("found_position %0d, expected %0d", d[7:3],
                                 exp_r.found_position));
            if (d[39:8] !== exp_r.read_value)
                report($sformatf("read_value %h, expected %h", d[39:8], exp_r.read_value));
            if (d[44:40] !== exp_r.count)
                report($sformatf("count %0d, expected %0d", d[44:40], exp_r.count));
            if (d[47:45] !== 3'b000)
                report($sformatf("pad bits %b not zero", d[47:45]));
        endtask
    endclass

    list_tracker board = new();

    positional_array_list_top #(.DEPTH(LIST_DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.apply_command(cmd, val, pos);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                3: return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        if (r < 45) return DATA_W'($urandom_range(7));   // small pool gives duplicates
        return $urandom;
    endfunction

    task automatic pick_item(output logic [CMD_W-1:0] cmd, output logic [DATA_W-1:0] val,
                             output logic [POS_W-1:0] pos);
        int r;
        int n;
        n   = board.len;
        val = pick_value();
        pos = POS_W'($urandom_range(31));
        if (!fill_active && $urandom_range(99) < 3) begin
            fill_active = 1'b1;
            full_pokes  = $urandom_range(1, 3);
        end
        if (fill_active) begin
            if (n < LIST_DEPTH) begin
                if ($urandom_range(1)) cmd = CMD_APPEND;
                else begin
                    cmd = CMD_INSERT;
                    pos = POS_W'($urandom_range(1, n + 1));
                end
            end else begin
                cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
                full_pokes--;
                if (full_pokes <= 0) fill_active = 1'b0;
            end
            return;
        end
        if ($urandom_range(99) < 10) begin
            cmd = CMD_W'($urandom_range(7));
            return;
        end
        r = $urandom_range(99);
        if (r < 20) cmd = CMD_APPEND;
        else if (r < 40) begin
            cmd = CMD_INSERT;
            pos = POS_W'($urandom_range(1, n + 1));
        end else if (r < 58) begin
            cmd = CMD_DELETE;
            if (n > 0) pos = POS_W'($urandom_range(1, n));
        end else if (r < 76) begin
            cmd = CMD_FIND;
            if (n > 0 && $urandom_range(99) < 70) val = board.words[$urandom_range(n - 1)];
        end else if (r < 96) begin
            cmd = CMD_READ;
            if (n > 0) pos = POS_W'($urandom_range(1, n));
        end else cmd = CMD_CLEAR;
    endtask

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, bounds, extremes, first match, unused codes
        send_cmd(CMD_CLEAR,  32'h0, 5'd0);
        send_cmd(CMD_DELETE, 32'h0, 5'd1);
        send_cmd(CMD_READ,   32'h0, 5'd1);
        send_cmd(CMD_FIND,   32'h0, 5'd0);
        send_cmd(CMD_INSERT, 32'h1, 5'd0);
        send_cmd(CMD_INSERT, 32'h1, 5'd2);
        send_cmd(CMD_INSERT, 32'h8000_0000, 5'd1);
        send_cmd(CMD_APPEND, 32'h7fff_ffff, 5'd0);
        send_cmd(CMD_APPEND, 32'h0, 5'd0);
        send_cmd(CMD_APPEND, 32'hffff_ffff, 5'd0);
        send_cmd(CMD_INSERT, 32'h5, 5'd5);
        send_cmd(CMD_INSERT, 32'h7fff_ffff, 5'd3);
        send_cmd(CMD_FIND,   32'h7fff_ffff, 5'd0);
        send_cmd(CMD_FIND,   32'h0001_2345, 5'd0);
        send_cmd(CMD_READ,   32'h0, 5'd0);
        send_cmd(CMD_READ,   32'h0, 5'd7);
        send_cmd(CMD_READ,   32'hffff_ffff, 5'd31);
        send_cmd(CMD_READ,   32'h0, 5'd6);
        send_cmd(CMD_DELETE, 32'h0, 5'd0);
        send_cmd(CMD_DELETE, 32'hffff_ffff, 5'd31);
        send_cmd(CMD_DELETE, 32'h0, 5'd1);
        send_cmd(CMD_DELETE, 32'h0, 5'd5);
        send_cmd(3'd6, $urandom, 5'($urandom_range(31)));
        send_cmd(3'd7, $urandom, 5'($urandom_range(31)));
        send_cmd(CMD_CLEAR,  32'h0, 5'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick_item(cmd, val, pos);
                send_cmd(cmd, val, pos);
            end
            // hold off until the block has drained everything
            s_tvalid <= 1'b0;
            while (board.outstanding() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
